// ===== design/ckp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and the queued operation type of the complex Kronecker product core.
package ckp_pkg;

    localparam int MAX_DIM_DEFAULT = 4;
    localparam int QUEUE_DEPTH     = 4;

    localparam int ACT_W      = 2;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 2;
    localparam int VAL_W      = 16;
    localparam int OUT_COL_W  = 4;
    localparam int PROD_W     = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;

    localparam logic [ACT_W-1:0] ACT_WRITE_A = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE_B = 2'd1;
    localparam logic [ACT_W-1:0] ACT_EMIT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd3;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 3'd2;

    // Highest column that a single emitted row may reach.
    localparam logic [OUT_COL_W-1:0] OUT_COL_MAX = 4'd15;

    typedef enum logic [1:0] {
        OP_WRITE_A,
        OP_WRITE_B,
        OP_EMIT
    } op_kind_t;

    // For writes row_a is the matrix row; for an emit row_a is the row of A
    // and row_b the row of B that the product row decomposes into.
    typedef struct packed {
        op_kind_t                 kind;
        logic [ROW_W-1:0]         row_a;
        logic [ROW_W-1:0]         row_b;
        logic [COL_W-1:0]         col;
        logic [ROW_W-1:0]         prod_row;
        logic signed [VAL_W-1:0]  value_re;
        logic signed [VAL_W-1:0]  value_im;
    } op_t;

endpackage

// ===== design/complex_kronecker_product_core.sv =====
`timescale 1ns / 1ps
// Top level of the complex Kronecker product core: size registers, front end, queue, back end.
//
// The core holds two complex matrices A and B (signed Q8.8 parts, up to MAX_DIM by MAX_DIM
// each) and returns rows of their Kronecker product on request. A write of an A or B entry
// takes one transfer on the input channel and is dropped when its row or column lies outside
// the programmed size of that matrix. An emit request names a product row; the core answers
// with every entry of that row in column order, as exact Q16.16 complex products in 33 bits,
// and marks the final entry with last. A row number of rows_a * rows_b or more gives no
// results, and at most sixteen entries are returned per row. Size registers read 0 as 1 and
// clamp anything above MAX_DIM to MAX_DIM; they are to be written only while the core is idle.
// The front end accepts a write every cycle while the queue has room, whereas an emit request
// keeps it busy through the repeated subtraction that splits the product row into a row of A
// and a row of B, until the split request is queued or, if out of range, dropped. The back end
// drains the queue in order: a write goes straight into its store, and an emit leaves the queue
// and then walks cols_a * cols_b columns (sixteen at most) at one entry per cycle, while the
// output is not stalled, through the store read, multiply and combine registers. A four-deep
// queue separates the two ends; while the output register awaits its transfer the whole
// multiply pipeline holds still.
// Entries read from a store that was never written since reset return unspecified values.
module complex_kronecker_product_core #(
    parameter int MAX_DIM     = ckp_pkg::MAX_DIM_DEFAULT,
    parameter int QUEUE_DEPTH = ckp_pkg::QUEUE_DEPTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ckp_pkg::ACT_W-1:0]             s_action,
    input  logic [ckp_pkg::ROW_W-1:0]             s_row_index,
    input  logic [ckp_pkg::COL_W-1:0]             s_col_index,
    input  logic signed [ckp_pkg::VAL_W-1:0]      s_value_re,
    input  logic signed [ckp_pkg::VAL_W-1:0]      s_value_im,
    // Result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ckp_pkg::ROW_W-1:0]             m_out_row,
    output logic [ckp_pkg::OUT_COL_W-1:0]         m_out_col,
    output logic signed [ckp_pkg::PROD_W-1:0]     m_product_re,
    output logic signed [ckp_pkg::PROD_W-1:0]     m_product_im,
    output logic                                  m_last,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ckp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ckp_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int DATA_W = ckp_pkg::CFG_DATA_W;

    logic [DATA_W-1:0] rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic [DIM_W-1:0]  rows_a, cols_a, rows_b, cols_b;

    logic         push_valid, push_ready;
    logic         pop_valid, pop_ready;
    ckp_pkg::op_t push_op, pop_op;

    // A size of zero behaves as one, and anything beyond the store as the full store.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DATA_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // The size registers are always able to take a transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg <= ckp_pkg::DIM_RESET;
            cols_a_reg <= ckp_pkg::DIM_RESET;
            rows_b_reg <= ckp_pkg::DIM_RESET;
            cols_b_reg <= ckp_pkg::DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ckp_pkg::REG_ROWS_A: rows_a_reg <= cfg_data;
                ckp_pkg::REG_COLS_A: cols_a_reg <= cfg_data;
                ckp_pkg::REG_ROWS_B: rows_b_reg <= cfg_data;
                ckp_pkg::REG_COLS_B: cols_b_reg <= cfg_data;
                default: begin
                    // Indexes without a register are ignored.
                end
            endcase
        end
    end

    always_comb begin
        rows_a = clamp_dim(rows_a_reg);
        cols_a = clamp_dim(cols_a_reg);
        rows_b = clamp_dim(rows_b_reg);
        cols_b = clamp_dim(cols_b_reg);
    end

    // Front end: range checks on writes and the split of a product row.
    ckp_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_row_index (s_row_index),
        .s_col_index (s_col_index),
        .s_value_re  (s_value_re),
        .s_value_im  (s_value_im),
        .rows_a      (rows_a),
        .cols_a      (cols_a),
        .rows_b      (rows_b),
        .cols_b      (cols_b),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_op     (push_op)
    );

    // Operations keep their order through the queue, so a write issued after an emit
    // request can never change the entries that request reads.
    ckp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    // Back end: stores, column walk and the multiply pipeline feeding the output register.
    ckp_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_op       (pop_op),
        .cols_a       (cols_a),
        .cols_b       (cols_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_product_re (m_product_re),
        .m_product_im (m_product_im),
        .m_last       (m_last)
    );

`ifndef ASSERT_OFF
    // An accepted emit request always occupies the front end in the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ckp_pkg::ACT_EMIT)) |=> !s_ready)
        else $error("front end took a request while splitting a product row");

    // The sixteenth entry of a row is always its final one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_out_col != ckp_pkg::OUT_COL_MAX))
        else $error("product row continued past its sixteenth entry");

    // Only rows inside the product are ever answered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_out_row) < int'(rows_a) * int'(rows_b)))
        else $error("result given for a product row out of range");
`endif

endmodule

// ===== design/ckp_queue.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue of operations between the front and back ends.
module ckp_queue #(
    parameter int DEPTH = ckp_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  ckp_pkg::op_t  push_op,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ckp_pkg::op_t  pop_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ckp_pkg::op_t     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== design/ckp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, drops out-of-range ones and splits product rows.
module ckp_front #(
    parameter int MAX_DIM = ckp_pkg::MAX_DIM_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ckp_pkg::ACT_W-1:0]         s_action,
    input  logic [ckp_pkg::ROW_W-1:0]         s_row_index,
    input  logic [ckp_pkg::COL_W-1:0]         s_col_index,
    input  logic signed [ckp_pkg::VAL_W-1:0]  s_value_re,
    input  logic signed [ckp_pkg::VAL_W-1:0]  s_value_im,
    input  logic [$clog2(MAX_DIM+1)-1:0]      rows_a,
    input  logic [$clog2(MAX_DIM+1)-1:0]      cols_a,
    input  logic [$clog2(MAX_DIM+1)-1:0]      rows_b,
    input  logic [$clog2(MAX_DIM+1)-1:0]      cols_b,
    output logic                              push_valid,
    input  logic                              push_ready,
    output ckp_pkg::op_t                      push_op
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int ROW_W = ckp_pkg::ROW_W;

    typedef enum logic {
        F_IDLE,
        F_DIVIDE
    } front_state_t;

    front_state_t     state_reg;
    logic [ROW_W-1:0] rem_reg;
    logic [ROW_W-1:0] quo_reg;
    logic [ROW_W-1:0] row_reg;

    logic [DIM_W-1:0] lim_rows;
    logic [DIM_W-1:0] lim_cols;
    logic             is_write;
    logic             write_ok;
    logic             rem_ge;
    logic             quo_ok;

    always_comb begin
        lim_rows = (s_action == ckp_pkg::ACT_WRITE_A) ? rows_a : rows_b;
        lim_cols = (s_action == ckp_pkg::ACT_WRITE_A) ? cols_a : cols_b;
        is_write = (s_action == ckp_pkg::ACT_WRITE_A) || (s_action == ckp_pkg::ACT_WRITE_B);
        write_ok = (s_row_index < ROW_W'(lim_rows)) &&
                   (ROW_W'(s_col_index) < ROW_W'(lim_cols));
        rem_ge   = (rem_reg >= ROW_W'(rows_b));
        // The product row is in range exactly when its quotient is a row of A.
        quo_ok   = (quo_reg < ROW_W'(rows_a));
    end

    always_comb begin
        s_ready    = 1'b0;
        push_valid = 1'b0;
        push_op    = '0;
        case (state_reg)
            F_IDLE: begin
                s_ready          = push_ready;
                push_valid       = s_valid && is_write && write_ok;
                push_op.kind     = (s_action == ckp_pkg::ACT_WRITE_A) ?
                                   ckp_pkg::OP_WRITE_A : ckp_pkg::OP_WRITE_B;
                push_op.row_a    = s_row_index;
                push_op.col      = s_col_index;
                push_op.value_re = s_value_re;
                push_op.value_im = s_value_im;
            end
            F_DIVIDE: begin
                push_valid       = !rem_ge && quo_ok;
                push_op.kind     = ckp_pkg::OP_EMIT;
                push_op.row_a    = quo_reg;
                push_op.row_b    = rem_reg;
                push_op.prod_row = row_reg;
            end
            default: begin
                s_ready    = 1'b0;
                push_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            rem_reg   <= '0;
            quo_reg   <= '0;
            row_reg   <= '0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid && s_ready && (s_action == ckp_pkg::ACT_EMIT)) begin
                        rem_reg   <= s_row_index;
                        quo_reg   <= '0;
                        row_reg   <= s_row_index;
                        state_reg <= F_DIVIDE;
                    end
                end
                F_DIVIDE: begin
                    if (rem_ge) begin
                        rem_reg <= rem_reg - ROW_W'(rows_b);
                        quo_reg <= quo_reg + 1'b1;
                    end else if (!quo_ok || push_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/ckp_back.sv =====
`timescale 1ns / 1ps
// Back end: matrix stores, column walk and the complex multiply pipeline.
module ckp_back #(
    parameter int MAX_DIM = ckp_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  pop_valid,
    output logic                                  pop_ready,
    input  ckp_pkg::op_t                          pop_op,
    input  logic [$clog2(MAX_DIM+1)-1:0]          cols_a,
    input  logic [$clog2(MAX_DIM+1)-1:0]          cols_b,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ckp_pkg::ROW_W-1:0]             m_out_row,
    output logic [ckp_pkg::OUT_COL_W-1:0]         m_out_col,
    output logic signed [ckp_pkg::PROD_W-1:0]     m_product_re,
    output logic signed [ckp_pkg::PROD_W-1:0]     m_product_im,
    output logic                                  m_last
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int ROW_W  = ckp_pkg::ROW_W;
    localparam int OCOL_W = ckp_pkg::OUT_COL_W;
    localparam int VAL_W  = ckp_pkg::VAL_W;
    localparam int PROD_W = ckp_pkg::PROD_W;
    localparam int MUL_W  = 2 * VAL_W;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } back_state_t;

    back_state_t       state_reg;
    logic [IDX_W-1:0]  i_reg, k_reg, j_reg, l_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [OCOL_W-1:0] c_reg;

    logic [2*VAL_W-1:0] a_store_reg [CELLS];
    logic [2*VAL_W-1:0] b_store_reg [CELLS];
    logic [2*VAL_W-1:0] rd_a_reg, rd_b_reg;

    logic              s1_valid_reg, s2_valid_reg, m_valid_reg;
    logic [ROW_W-1:0]  s1_row_reg, s2_row_reg, m_out_row_reg;
    logic [OCOL_W-1:0] s1_col_reg, s2_col_reg, m_out_col_reg;
    logic              s1_last_reg, s2_last_reg, m_last_reg;

    logic signed [MUL_W-1:0]  pr_rr_reg, pr_ii_reg, pr_ri_reg, pr_ir_reg;
    logic signed [PROD_W-1:0] m_product_re_reg, m_product_im_reg;

    logic signed [VAL_W-1:0] a_re, a_im, b_re, b_im;
    logic              adv;
    logic              issue;
    logic              l_wrap, j_wrap, col_last;
    logic              do_pop;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

    assign adv       = !m_valid_reg || m_ready;
    assign issue     = (state_reg == B_EMIT) && adv;
    assign pop_ready = (state_reg == B_IDLE);
    assign do_pop    = pop_valid && pop_ready;

    always_comb begin
        l_wrap    = ((DIM_W'(l_reg) + DIM_W'(1)) == cols_b);
        j_wrap    = ((DIM_W'(j_reg) + DIM_W'(1)) == cols_a);
        // A row stops at the end of its columns or at the sixteenth entry.
        col_last  = (l_wrap && j_wrap) || (c_reg == ckp_pkg::OUT_COL_MAX);
        wr_addr   = ADDR_W'(int'(pop_op.row_a) * MAX_DIM + int'(pop_op.col));
        rd_addr_a = ADDR_W'(int'(i_reg) * MAX_DIM + int'(j_reg));
        rd_addr_b = ADDR_W'(int'(k_reg) * MAX_DIM + int'(l_reg));
        a_re      = signed'(rd_a_reg[VAL_W-1:0]);
        a_im      = signed'(rd_a_reg[2*VAL_W-1:VAL_W]);
        b_re      = signed'(rd_b_reg[VAL_W-1:0]);
        b_im      = signed'(rd_b_reg[2*VAL_W-1:VAL_W]);
    end

    always_ff @(posedge aclk) begin
        if (do_pop && (pop_op.kind == ckp_pkg::OP_WRITE_A)) begin
            a_store_reg[wr_addr] <= {pop_op.value_im, pop_op.value_re};
        end
        if (do_pop && (pop_op.kind == ckp_pkg::OP_WRITE_B)) begin
            b_store_reg[wr_addr] <= {pop_op.value_im, pop_op.value_re};
        end
        if (issue) begin
            rd_a_reg <= a_store_reg[rd_addr_a];
            rd_b_reg <= b_store_reg[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            i_reg        <= '0;
            k_reg        <= '0;
            j_reg        <= '0;
            l_reg        <= '0;
            row_reg      <= '0;
            c_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (adv) begin
                s1_valid_reg     <= issue;
                s2_valid_reg     <= s1_valid_reg;
                m_valid_reg      <= s2_valid_reg;
                s1_row_reg       <= row_reg;
                s1_col_reg       <= c_reg;
                s1_last_reg      <= col_last;
                s2_row_reg       <= s1_row_reg;
                s2_col_reg       <= s1_col_reg;
                s2_last_reg      <= s1_last_reg;
                pr_rr_reg        <= MUL_W'(a_re) * MUL_W'(b_re);
                pr_ii_reg        <= MUL_W'(a_im) * MUL_W'(b_im);
                pr_ri_reg        <= MUL_W'(a_re) * MUL_W'(b_im);
                pr_ir_reg        <= MUL_W'(a_im) * MUL_W'(b_re);
                m_out_row_reg    <= s2_row_reg;
                m_out_col_reg    <= s2_col_reg;
                m_last_reg       <= s2_last_reg;
                m_product_re_reg <= {pr_rr_reg[MUL_W-1], pr_rr_reg} -
                                    {pr_ii_reg[MUL_W-1], pr_ii_reg};
                m_product_im_reg <= {pr_ri_reg[MUL_W-1], pr_ri_reg} +
                                    {pr_ir_reg[MUL_W-1], pr_ir_reg};
            end
            case (state_reg)
                B_IDLE: begin
                    if (do_pop && (pop_op.kind == ckp_pkg::OP_EMIT)) begin
                        i_reg     <= IDX_W'(pop_op.row_a);
                        k_reg     <= IDX_W'(pop_op.row_b);
                        row_reg   <= pop_op.prod_row;
                        j_reg     <= '0;
                        l_reg     <= '0;
                        c_reg     <= '0;
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    if (adv) begin
                        c_reg <= c_reg + 1'b1;
                        if (l_wrap) begin
                            l_reg <= '0;
                            j_reg <= j_reg + 1'b1;
                        end else begin
                            l_reg <= l_reg + 1'b1;
                        end
                        if (col_last) begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_row    = m_out_row_reg;
    assign m_out_col    = m_out_col_reg;
    assign m_product_re = m_product_re_reg;
    assign m_product_im = m_product_im_reg;
    assign m_last       = m_last_reg;

endmodule
